[hdl/fsr_pkg.sv]
// ============================================================================
// Foveated shading-rate package
// Shared widths, register indexes and rate codes for the tile map block.
// ============================================================================
package fsr_pkg;

   // Item field widths.
   localparam int TILE_W  = 10;
   localparam int LEVEL_W = 3;

   // Configuration register widths.
   localparam int SIZE_W     = 11;
   localparam int INV_W      = 16;
   localparam int COORD_W    = 16;
   localparam int CENTER_W   = 2 * COORD_W;
   localparam int RADIUS_W   = 16;
   localparam int NUM_RADII  = 4;
   localparam int RADII_W    = NUM_RADII * RADIUS_W;
   localparam int XW_W       = 16;

   // Configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   // Reset value of the horizontal weight: 4.0 in Q4.12.
   localparam logic [XW_W-1:0] X_WEIGHT_RESET = 16'h4000;

   // Default largest grid.
   localparam int unsigned DEFAULT_MAX_GRID_WIDTH  = 1024;
   localparam int unsigned DEFAULT_MAX_GRID_HEIGHT = 1024;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_RENDER_WIDTH  = 3'd0,
      REG_RENDER_HEIGHT = 3'd1,
      REG_INV_WIDTH     = 3'd2,
      REG_INV_HEIGHT    = 3'd3,
      REG_LEFT_CENTER   = 3'd4,
      REG_RIGHT_CENTER  = 3'd5,
      REG_RADII         = 3'd6,
      REG_X_WEIGHT      = 3'd7
   } csr_index_type;

   typedef enum logic [LEVEL_W-1:0] {
      RATE_FULL      = 3'd0,
      RATE_HALF      = 3'd1,
      RATE_QUARTER   = 3'd2,
      RATE_SIXTEENTH = 3'd3,
      RATE_CULL      = 3'd4
   } rate_type;

endpackage

[hdl/fsr_req_if.sv]
// ============================================================================
// Tile request channel
// Valid/ready channel that carries one tile coordinate per item.
// ============================================================================
interface fsr_req_if import fsr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TILE_W-1:0] tile_x;
   logic [TILE_W-1:0] tile_y;

   modport source (output valid, output tile_x, output tile_y, input ready);
   modport sink   (input valid, input tile_x, input tile_y, output ready);
endinterface

[hdl/fsr_rsp_if.sv]
// ============================================================================
// Rate response channel
// Valid/ready channel that carries one shading-rate level per item.
// ============================================================================
interface fsr_rsp_if import fsr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] rate_level;

   modport source (output valid, output rate_level, input ready);
   modport sink   (input valid, input rate_level, output ready);
endinterface

[hdl/foveated_shading_rate_tile_map_top.sv]
// ============================================================================
// Foveated shading-rate tile map
// Maps a shading-tile coordinate to a shading-rate level by comparing a
// weighted elliptical squared distance to the eye center of the tile's
// half of the render width against four squared radii.
// ============================================================================
//
//   Channel   Direction  Contents                       Handshake
//   req_ch    in         tile_x, tile_y (10 b each)      valid / ready
//   rsp_ch    out        rate_level (3 b)                valid / ready
//   csr_*     in         csr_index, csr_wdata (64 b)     csr_we, no wait
//
// The block accepts one item per cycle while req_ch.ready is high. An accepted
// item enters the first of six pipeline stages at the accepting edge, and the
// output register follows the last stage and drives rsp_ch.valid.
// The depth is set by the chain normalize, difference, square,
// weight, clamp and compare, one register stage each.
// When the output register holds a result that is not taken, the whole
// pipeline freezes and req_ch.ready drops in the same cycle; nothing is lost.
// Reset is synchronous and active high; it empties the pipeline and returns
// the configuration registers to zero, except the horizontal weight, which becomes 4.0.
//
// Arithmetic: fx = tile_x * inv_width (Q0.16, exact), dx = |fx - cx|,
// X = dx^2 * x_weight and Y = dy^2 * 4096, both in units of 2^-44.
// A radius r gives the threshold r^2 * 2^18 in the same units. Thresholds
// are below 2^50, so every term is clamped to 50 bits plus an overflow flag,
// and a flagged term is never below any threshold, just as a saturated sum.
// ============================================================================
module foveated_shading_rate_tile_map_top
   import fsr_pkg::*;
#(
   parameter int unsigned MAX_GRID_WIDTH  = DEFAULT_MAX_GRID_WIDTH,
   parameter int unsigned MAX_GRID_HEIGHT = DEFAULT_MAX_GRID_HEIGHT
) (
   input  logic                   clock,
   input  logic                   reset,
   fsr_req_if.sink                req_ch,
   fsr_rsp_if.source              rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // Derived widths of the datapath.
   localparam int FX_W     = TILE_W + INV_W;          // normalized coordinate
   localparam int SQ_W     = 2 * FX_W;                // squared difference
   localparam int HALF_W   = SQ_W / 2;                // partial product split
   localparam int PP_W     = HALF_W + XW_W;           // one partial product
   localparam int XT_W     = SQ_W + XW_W;             // full weighted term
   localparam int Y_SHIFT  = 12;                      // times 4096
   localparam int T_SHIFT  = 18;                      // threshold scale
   localparam int THR_W    = 2 * RADIUS_W + T_SHIFT;  // threshold width
   localparam int NSTAGE   = 6;

   // ------------------------------------------------------------------------
   // Configuration registers.
   // ------------------------------------------------------------------------
   logic [SIZE_W-1:0]   render_width_ff;
   logic [SIZE_W-1:0]   render_height_ff;
   logic [INV_W-1:0]    inv_width_ff;
   logic [INV_W-1:0]    inv_height_ff;
   logic [CENTER_W-1:0] left_center_ff;
   logic [CENTER_W-1:0] right_center_ff;
   logic [RADII_W-1:0]  radii_ff;
   logic [XW_W-1:0]     x_weight_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         render_width_ff  <= '0;
         render_height_ff <= '0;
         inv_width_ff     <= '0;
         inv_height_ff    <= '0;
         left_center_ff   <= '0;
         right_center_ff  <= '0;
         radii_ff         <= '0;
         x_weight_ff      <= X_WEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            REG_RENDER_WIDTH:  render_width_ff  <= csr_wdata[SIZE_W-1:0];
            REG_RENDER_HEIGHT: render_height_ff <= csr_wdata[SIZE_W-1:0];
            REG_INV_WIDTH:     inv_width_ff     <= csr_wdata[INV_W-1:0];
            REG_INV_HEIGHT:    inv_height_ff    <= csr_wdata[INV_W-1:0];
            REG_LEFT_CENTER:   left_center_ff   <= csr_wdata[CENTER_W-1:0];
            REG_RIGHT_CENTER:  right_center_ff  <= csr_wdata[CENTER_W-1:0];
            REG_RADII:         radii_ff         <= csr_wdata[RADII_W-1:0];
            REG_X_WEIGHT:      x_weight_ff      <= csr_wdata[XW_W-1:0];
            default: ;
         endcase
      end
   end

   // Squared radii are recomputed every cycle from the radius register. A write
   // reaches them through that register, well before the next item can use them.
   logic [THR_W-1:0] thr_ff [NUM_RADII];

   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_RADII; k++) begin
         thr_ff[k] <= {32'(radii_ff[k*RADIUS_W +: RADIUS_W]) *
                       32'(radii_ff[k*RADIUS_W +: RADIUS_W]), T_SHIFT'(0)};
      end
   end

   // ------------------------------------------------------------------------
   // Pipeline control. Every stage moves when the output register is free
   // or being emptied; otherwise everything holds.
   // ------------------------------------------------------------------------
   logic              advance;
   logic [NSTAGE:1]   vld_ff;
   logic              out_valid_ff;
   logic [LEVEL_W-1:0] out_level_ff;

   assign advance      = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         vld_ff       <= {vld_ff[NSTAGE-1:1], req_ch.valid};
         out_valid_ff <= vld_ff[NSTAGE];
      end
   end

   // Outside flag travels alongside the datapath.
   logic [NSTAGE:1] outside_ff;

   // ------------------------------------------------------------------------
   // Stage 1: range check, eye select, normalize.
   // ------------------------------------------------------------------------
   logic               outside_in;
   logic               use_left;
   logic [FX_W-1:0]    fx_ff, fy_ff;
   logic [COORD_W-1:0] cx_ff, cy_ff;
   logic [CENTER_W-1:0] center_sel;

   always_comb begin
      outside_in = ({1'b0, req_ch.tile_x} >= render_width_ff)  ||
                   ({1'b0, req_ch.tile_y} >= render_height_ff) ||
                   (32'(req_ch.tile_x) >= MAX_GRID_WIDTH)      ||
                   (32'(req_ch.tile_y) >= MAX_GRID_HEIGHT);
      use_left   = req_ch.tile_x < render_width_ff[SIZE_W-1:1];
      center_sel = use_left ? left_center_ff : right_center_ff;
   end

   // ------------------------------------------------------------------------
   // Stages 2 to 5 registers.
   // ------------------------------------------------------------------------
   logic [FX_W-1:0]  dx_ff, dy_ff;
   logic [SQ_W-1:0]  dx2_ff, dy2_ff;
   logic [PP_W-1:0]  pl_ff, ph_ff;
   logic [THR_W-1:0] y4_ff, y5_ff, x5_ff;
   logic             ybig4_ff, ybig5_ff, xbig5_ff;
   logic [XT_W-1:0]  xt_full;

   assign xt_full = XT_W'(pl_ff) + {ph_ff, HALF_W'(0)};

   // ------------------------------------------------------------------------
   // Stage 6: the three sums against the thresholds.
   // ------------------------------------------------------------------------
   logic [THR_W:0]   s0;
   logic [THR_W+1:0] s1, s2;
   logic             big5;
   logic [NUM_RADII-1:0] lt0_in, lt0_ff;
   logic             lt1_in, lt2_in, lt1_ff, lt2_ff;
   rate_type         level_sel;
   logic [LEVEL_W-1:0] level_in;

   always_comb begin
      big5 = xbig5_ff || ybig5_ff;
      s0   = {1'b0, x5_ff} + {1'b0, y5_ff};
      s1   = {2'b0, x5_ff} + {1'b0, y5_ff, 1'b0};
      s2   = {1'b0, x5_ff, 1'b0} + {2'b0, y5_ff};
      for (int k = 0; k < NUM_RADII; k++) begin
         lt0_in[k] = !big5 && (s0 < {1'b0, thr_ff[k]});
      end
      lt1_in = !big5 && (s1 < {2'b0, thr_ff[0]});
      lt2_in = !big5 && (s2 < {2'b0, thr_ff[0]});
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         // Stage 1
         outside_ff[1] <= outside_in;
         fx_ff         <= req_ch.tile_x * inv_width_ff;
         fy_ff         <= req_ch.tile_y * inv_height_ff;
         cx_ff         <= center_sel[CENTER_W-1:COORD_W];
         cy_ff         <= center_sel[COORD_W-1:0];
         // Stage 2
         outside_ff[2] <= outside_ff[1];
         dx_ff <= (fx_ff >= FX_W'(cx_ff)) ? fx_ff - FX_W'(cx_ff) : FX_W'(cx_ff) - fx_ff;
         dy_ff <= (fy_ff >= FX_W'(cy_ff)) ? fy_ff - FX_W'(cy_ff) : FX_W'(cy_ff) - fy_ff;
         // Stage 3
         outside_ff[3] <= outside_ff[2];
         dx2_ff        <= dx_ff * dx_ff;
         dy2_ff        <= dy_ff * dy_ff;
         // Stage 4: weight split in two partial products; Y is a shift.
         outside_ff[4] <= outside_ff[3];
         pl_ff         <= dx2_ff[HALF_W-1:0] * x_weight_ff;
         ph_ff         <= dx2_ff[SQ_W-1:HALF_W] * x_weight_ff;
         ybig4_ff      <= |dy2_ff[SQ_W-1:THR_W-Y_SHIFT];
         y4_ff         <= {dy2_ff[THR_W-Y_SHIFT-1:0], Y_SHIFT'(0)};
         // Stage 5: combine partial products and clamp.
         outside_ff[5] <= outside_ff[4];
         xbig5_ff      <= |xt_full[XT_W-1:THR_W];
         x5_ff         <= xt_full[THR_W-1:0];
         ybig5_ff      <= ybig4_ff;
         y5_ff         <= y4_ff;
         // Stage 6
         outside_ff[6] <= outside_ff[5];
         lt0_ff        <= lt0_in;
         lt1_ff        <= lt1_in;
         lt2_ff        <= lt2_in;
         // Output register
         out_level_ff  <= level_in;
      end
   end

   // ------------------------------------------------------------------------
   // Level selection into the output register.
   // ------------------------------------------------------------------------
   always_comb begin
      if (outside_ff[NSTAGE]) begin
         level_sel = RATE_SIXTEENTH;
      end else if (lt0_ff[0]) begin
         // Full rate only if one of the stretched distances is also inside.
         level_sel = (lt1_ff || lt2_ff) ? RATE_FULL : RATE_HALF;
      end else if (lt0_ff[1]) begin
         level_sel = RATE_HALF;
      end else if (lt0_ff[2]) begin
         level_sel = RATE_QUARTER;
      end else if (lt0_ff[3]) begin
         level_sel = RATE_SIXTEENTH;
      end else begin
         level_sel = RATE_CULL;
      end
      level_in = level_sel;
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.rate_level = out_level_ff;

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------
   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_ch.valid)
      else $error("result valid right after reset");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> vld_ff[1])
      else $error("accepted item did not enter the first stage");

   a_last_to_out: assert property (@(posedge clock) disable iff (reset)
      advance |=> (out_valid_ff == $past(vld_ff[NSTAGE])))
      else $error("last stage valid did not reach the output register");

   a_outside_level: assert property (@(posedge clock) disable iff (reset)
      (advance && vld_ff[NSTAGE] && outside_ff[NSTAGE]) |=>
      (rsp_ch.rate_level == RATE_SIXTEENTH))
      else $error("tile outside the render area did not get the sixteenth rate");

   a_stretch_inside: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[NSTAGE] && (lt1_ff || lt2_ff)) |-> lt0_ff[0])
      else $error("stretched distance inside while plain distance is not");

endmodule
